// ===== design/cpr_pkg.sv =====
// Shared types, codes and constants for the clock page replacement block.
`default_nettype none

package cpr_pkg;

  localparam int unsigned DEFAULT_FRAMES = 16;
  localparam int unsigned FRAME_W        = 4;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned FIU_W          = 5;
  localparam int unsigned COUNT_W        = 32;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_W          = FIU_W;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FAULT = 2'd2;

  localparam logic ALG_CLOCK   = 1'b0;
  localparam logic ALG_CLOCK_M = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b1;

  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] chosen_frame;
    logic               needs_writeback;
    logic               took_empty;
    logic [COUNT_W-1:0] victim_count;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

// ===== design/cpr_datapath.sv =====
// Frame bit vectors, clock hand, eviction counter, configuration and result registers.
`default_nettype none

module cpr_datapath #(
  parameter int unsigned FRAMES = cpr_pkg::DEFAULT_FRAMES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  cpr_pkg::req_t                  req_i,
  input  cpr_pkg::cmd_t                  cmd_i,
  output cpr_pkg::status_t               status_o,
  output cpr_pkg::rsp_t                  rsp_o
);
  import cpr_pkg::*;

  localparam int unsigned IW  = $clog2(FRAMES);
  localparam int unsigned NW0 = $clog2(FRAMES + 1);
  localparam int unsigned NW  = (NW0 > FIU_W) ? NW0 : FIU_W;
  localparam logic [NW-1:0] FRAMES_N = NW'(FRAMES);

  logic [FRAMES-1:0]  occ_q, use_q, dirty_q;
  logic [IW-1:0]      hand_q, start_q;
  logic [1:0]         lap_q;
  logic [COUNT_W-1:0] evict_q;
  logic               alg_q;
  logic [FIU_W-1:0]   fiu_q;
  rsp_t               res_q, out_q;

  logic [NW-1:0] fiu_n, n_act, hand_inc;
  logic [IW-1:0] acc_idx, empty_idx, hand_start, pos, hand_nxt;
  logic          acc_hit, empty_found, take, lap_end, done;

  always_comb begin
    fiu_n = NW'(fiu_q);
    if (fiu_q == '0) begin
      n_act = NW'(1);
    end else if (fiu_n > FRAMES_N) begin
      n_act = FRAMES_N;
    end else begin
      n_act = fiu_n;
    end
  end

  assign acc_idx = IW'(req_i.frame);
  assign acc_hit = (NW'(req_i.frame) < n_act) && occ_q[acc_idx];

  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((NW'(i) < n_act) && !occ_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = IW'(i);
      end
    end
  end

  assign hand_start = (NW'(hand_q) >= n_act) ? '0 : hand_q;
  assign pos        = hand_q;
  assign hand_inc   = NW'(hand_q) + NW'(1);
  assign hand_nxt   = (hand_inc >= n_act) ? '0 : IW'(hand_inc);
  assign lap_end    = (hand_nxt == start_q);

  always_comb begin
    if (alg_q == ALG_CLOCK_M) begin
      take = lap_q[0] ? (!use_q[pos] && dirty_q[pos]) : (!use_q[pos] && !dirty_q[pos]);
      done = take || ((lap_q == 2'd3) && lap_end);
    end else begin
      take = !use_q[pos];
      done = take;
    end
  end

  assign status_o.need_scan = (req_i.req_type == REQ_FAULT) && !empty_found;
  assign status_o.scan_done = done;
  assign rsp_o              = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      use_q   <= '0;
      dirty_q <= '0;
      hand_q  <= '0;
      evict_q <= '0;
      alg_q   <= ALG_CLOCK;
      fiu_q   <= FIU_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALGORITHM:     alg_q <= cfg_wdata_i[0];
          CFG_FRAMES_IN_USE: fiu_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        if ((req_i.req_type == REQ_READ || req_i.req_type == REQ_WRITE) && acc_hit) begin
          use_q[acc_idx] <= 1'b1;
          if (req_i.req_type == REQ_WRITE) begin
            dirty_q[acc_idx] <= 1'b1;
          end
        end else if (req_i.req_type == REQ_FAULT) begin
          if (empty_found) begin
            occ_q[empty_idx]   <= 1'b1;
            use_q[empty_idx]   <= 1'b0;
            dirty_q[empty_idx] <= 1'b0;
          end else begin
            hand_q <= hand_start;
          end
        end
      end
      if (cmd_i.step) begin
        hand_q <= hand_nxt;
        if (done || alg_q == ALG_CLOCK || lap_q[0]) begin
          use_q[pos] <= 1'b0;
        end
        if (done) begin
          dirty_q[pos] <= 1'b0;
          evict_q      <= evict_q + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      start_q <= hand_start;
      lap_q   <= 2'd0;
      res_q.needs_writeback <= 1'b0;
      res_q.victim_count    <= evict_q;
      if (req_i.req_type == REQ_FAULT && empty_found) begin
        res_q.chosen_frame <= FRAME_W'(empty_idx);
        res_q.took_empty   <= 1'b1;
      end else begin
        res_q.chosen_frame <= '0;
        res_q.took_empty   <= 1'b0;
      end
    end
    if (cmd_i.step) begin
      if (lap_end) begin
        lap_q <= lap_q + 2'd1;
      end
      if (done) begin
        res_q.chosen_frame    <= FRAME_W'(pos);
        res_q.needs_writeback <= dirty_q[pos];
        res_q.took_empty      <= 1'b0;
        res_q.victim_count    <= evict_q + COUNT_W'(1);
      end
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/cpr_controller.sv =====
// Request sequencing state machine and result valid flag.
`default_nettype none

module cpr_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cpr_pkg::status_t status_i,
  output cpr_pkg::cmd_t    cmd_o
);
  import cpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.start = in_valid_i && (state_q == ST_IDLE);
    cmd_o.step  = (state_q == ST_SCAN);
    cmd_o.emit  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= status_i.need_scan ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd_o.emit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/clock_page_replacement.sv =====
// Top level of the clock page replacement block, plain clock or enhanced second-chance clock.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_req_i  (req_type, frame)
//  out     | output    | out_valid_o/out_ready_i| out_rsp_o (chosen_frame, needs_writeback,
//          |           |                        |            took_empty, victim_count)
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Read, write and empty-frame fault requests go from accept straight to the emit state,
// which registers the result. A fault that evicts first scans, the hand visiting up to
// n + 1 frames for plain clock and 3 * n + 1 for enhanced clock, n the active frame count;
// the hand steps one frame per cycle. One request is in work at a time.
// Reset clears all frame bits, the hand and the eviction count at once; no sweep.
// A result held by out_ready_i low stalls the next request only at its result stage.
`default_nettype none

module clock_page_replacement #(
  parameter int unsigned FRAMES = cpr_pkg::DEFAULT_FRAMES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cpr_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cpr_pkg::rsp_t                 out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpr_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import cpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  cpr_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpr_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== design/cpr_checker.sv =====
// Port-level checks for the clock page replacement block, bound to the top level.
`default_nettype none

module cpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cpr_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cpr_pkg::rsp_t out_rsp_o,
  input logic          cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request dropped or changed while waiting");

  a_empty_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.took_empty && out_rsp_o.needs_writeback))
    else $error("empty frame result flags a writeback");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in work");

  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !out_valid_o)
    else $error("register write while a request is in flight");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);

`default_nettype wire
